[rtl/core/tch_pkg.sv]
package tch_pkg;

	localparam int RING_DEPTH = 64;
	localparam int NUM_BINS   = 1024;

	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam int FILL_W  = $clog2(RING_DEPTH + 1);
	localparam int BIN_AW  = $clog2(NUM_BINS);
	localparam int STEP_W  = $clog2(BIN_AW + 1);
	localparam int OFF_W   = 33;

	localparam logic [31:0] WINDOW_RESET    = 32'd50000;
	localparam logic [15:0] BIN_WIDTH_RESET = 16'd100;
	localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;
	localparam logic [6:0]  PAIRS_MAX       = 7'd127;

	typedef enum logic [1:0] {
		ACT_PRIMARY   = 2'd0,
		ACT_SECONDARY = 2'd1,
		ACT_READ      = 2'd2,
		ACT_CLEAR     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_ORDER = 2'd2,
		ST_LOST  = 2'd3
	} status_t;

	localparam logic REG_WINDOW    = 1'b0;
	localparam logic REG_BIN_WIDTH = 1'b1;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] timestamp;
		logic [10:0] bin_select;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  pairs_found;
		logic [31:0] bin_count;
	} out_item_t;

	function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] head,
			input logic [FILL_W-1:0] off);
		logic [FILL_W:0] s;
		s = {{(FILL_W + 1 - RING_AW){1'b0}}, head} + {1'b0, off};
		if (s >= (FILL_W + 1)'(RING_DEPTH))
			s = s - (FILL_W + 1)'(RING_DEPTH);
		return s[RING_AW-1:0];
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] c);
		return (c == COUNT_MAX) ? c : c + 32'd1;
	endfunction

endpackage

[rtl/core/time_coincidence_histogrammer_core.sv]
// a read looks up its bin; an event is rejected when out of order, dropped when it repeats
// the newest entry of its own ring, else compared with every stored entry of the other ring,
// each pair that lands in a bin taking a serial bin division and histogram update
// clear writes one histogram entry per cycle
// one transaction at a time; the next is taken once the result is in the output register
// reset: rings empty, registers at defaults, then a clearing pass of all NUM_BINS entries of the
// histogram during which no transaction is accepted
module time_coincidence_histogrammer_core import tch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_CLR, S_RD, S_DUP, S_SCAN, S_CMP, S_DIV, S_HWR, S_STORE, S_DONE
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic init_q;
	logic [31:0] window_q;
	logic [15:0] bin_width_q;
	logic [FILL_W-1:0] fill_q [2];
	logic [RING_AW-1:0] head_q [2];
	logic [63:0] latest_q;
	logic [31:0] ovf_q;
	logic [BIN_AW-1:0] clr_idx_q;
	logic [FILL_W-1:0] k_q;
	logic [OFF_W-1:0] rem_q;
	logic [BIN_AW-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0] status_q;
	logic [6:0] pairs_q;
	logic [31:0] count_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [63:0] ring_mem [2*(2**RING_AW)];
	logic [31:0] hist_mem [2**BIN_AW];
	logic [63:0] ring_rdata;
	logic [31:0] hist_rdata;

	logic ring_re, ring_we, hist_re, hist_we;
	logic [RING_AW:0] ring_raddr, ring_waddr;
	logic [BIN_AW-1:0] hist_raddr, hist_waddr;
	logic [31:0] hist_wdata;

	logic own, oth;
	logic [15:0] wd;
	logic [63:0] gap;
	logic [OFF_W-1:0] off, div_sub, ovf_lim;
	logic div_ge;
	logic [BIN_AW-1:0] quo_next;

	assign own = (item_q.action == ACT_SECONDARY);
	assign oth = ~own;
	assign wd = (bin_width_q == 16'd0) ? 16'd1 : bin_width_q;
	assign gap = item_q.timestamp - ring_rdata;
	assign off = (item_q.action == ACT_PRIMARY)
		? {1'b0, window_q} - gap[OFF_W-1:0]
		: {1'b0, window_q} + gap[OFF_W-1:0];
	assign ovf_lim = OFF_W'(wd) << BIN_AW;
	assign div_sub = OFF_W'(wd) << step_q;
	assign div_ge = (rem_q >= div_sub);
	always_comb begin
		quo_next = quo_q;
		quo_next[step_q[$clog2(BIN_AW)-1:0]] = div_ge;
	end

	always_comb begin
		ring_re = 1'b0;
		ring_raddr = {own, ring_add(head_q[own], fill_q[own] - FILL_W'(1))};
		if (state_q == S_START && fill_q[own] != '0)
			ring_re = 1'b1;
		if (state_q == S_SCAN) begin
			ring_raddr = {oth, ring_add(head_q[oth], k_q)};
			ring_re = (k_q != fill_q[oth]);
		end
		ring_we = (state_q == S_STORE);
		ring_waddr = {own, (fill_q[own] < FILL_W'(RING_DEPTH))
			? ring_add(head_q[own], fill_q[own]) : head_q[own]};
		hist_re = 1'b0;
		hist_raddr = item_q.bin_select[BIN_AW-1:0];
		if (state_q == S_START && item_q.action == ACT_READ)
			hist_re = 1'b1;
		if (state_q == S_DIV && step_q == '0) begin
			hist_re = 1'b1;
			hist_raddr = quo_next;
		end
		hist_we = (state_q == S_CLR) || (state_q == S_HWR);
		hist_waddr = (state_q == S_CLR) ? clr_idx_q : quo_q;
		hist_wdata = (state_q == S_CLR) ? 32'd0 : bump(hist_rdata);
	end

	always_ff @(posedge clk) begin
		if (ring_we)
			ring_mem[ring_waddr] <= item_q.timestamp;
		if (ring_re)
			ring_rdata <= ring_mem[ring_raddr];
		if (hist_we)
			hist_mem[hist_waddr] <= hist_wdata;
		if (hist_re)
			hist_rdata <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			init_q <= 1'b1;
			window_q <= WINDOW_RESET;
			bin_width_q <= BIN_WIDTH_RESET;
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			head_q[0] <= '0;
			head_q[1] <= '0;
			latest_q <= '0;
			ovf_q <= '0;
			clr_idx_q <= '0;
			k_q <= '0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_WINDOW)
					window_q <= cfg_data;
				else
					bin_width_q <= cfg_data[15:0];
			end
			// in the done state the output register is handled below
			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						state_q <= S_START;
					end
				end
				S_START: begin
					status_q <= ST_OK;
					pairs_q <= '0;
					count_q <= '0;
					k_q <= '0;
					if (item_q.action == ACT_READ) begin
						state_q <= S_RD;
					end else if (item_q.action == ACT_CLEAR) begin
						clr_idx_q <= '0;
						ovf_q <= '0;
						state_q <= S_CLR;
					end else if (item_q.timestamp < latest_q) begin
						status_q <= ST_ORDER;
						state_q <= S_DONE;
					end else if (fill_q[own] != '0) begin
						state_q <= S_DUP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_CLR: begin
					clr_idx_q <= clr_idx_q + BIN_AW'(1);
					if (clr_idx_q == BIN_AW'(NUM_BINS - 1)) begin
						init_q <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_RD: begin
					if (item_q.bin_select < 11'(NUM_BINS))
						count_q <= hist_rdata;
					else if (item_q.bin_select == 11'(NUM_BINS))
						count_q <= ovf_q;
					state_q <= S_DONE;
				end
				S_DUP: begin
					if (ring_rdata == item_q.timestamp) begin
						status_q <= ST_DUP;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= (k_q == fill_q[oth]) ? S_STORE : S_CMP;
				end
				S_CMP: begin
					k_q <= k_q + FILL_W'(1);
					state_q <= S_SCAN;
					if (gap <= {32'd0, window_q}) begin
						if (pairs_q != PAIRS_MAX)
							pairs_q <= pairs_q + 7'd1;
						if (off >= ovf_lim) begin
							ovf_q <= bump(ovf_q);
						end else begin
							rem_q <= off;
							quo_q <= '0;
							step_q <= STEP_W'(BIN_AW - 1);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					quo_q <= quo_next;
					if (div_ge)
						rem_q <= rem_q - div_sub;
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0)
						state_q <= S_HWR;
				end
				S_HWR: begin
					state_q <= S_SCAN;
				end
				S_STORE: begin
					if (fill_q[own] < FILL_W'(RING_DEPTH)) begin
						fill_q[own] <= fill_q[own] + FILL_W'(1);
					end else begin
						head_q[own] <= ring_add(head_q[own], FILL_W'(1));
						status_q <= ST_LOST;
					end
					latest_q <= item_q.timestamp;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_q.status <= status_q;
						out_q.pairs_found <= pairs_q;
						out_q.bin_count <= count_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[rtl/core/tch_checker.sv]
module tch_checker import tch_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input out_item_t out_data,
	input logic      out_valid,
	input logic      out_stall
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// dropped or rejected events count no pairs
	a_no_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_DUP || out_data.status == ST_ORDER)
		|-> out_data.pairs_found == 7'd0)
		else $error("pairs on a dropped event");

	// a nonzero bin count only comes from a read, which has no status or pairs
	a_count_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bin_count != 32'd0
		|-> out_data.status == ST_OK && out_data.pairs_found == 7'd0)
		else $error("bin count on a non-read result");

	// pairs found never exceed the ring depth
	a_pairs_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pairs_found <= 7'(RING_DEPTH))
		else $error("pairs beyond ring depth");

	// one transaction in flight: an accepted item blocks the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken back to back");

endmodule

bind time_coincidence_histogrammer_core tch_checker u_tch_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_data(out_data),
	.out_valid(out_valid),
	.out_stall(out_stall)
);

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import tch_pkg::*;

	localparam int CYCLE_LIMIT = 10_000_000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	time_coincidence_histogrammer_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] win_cfg;
	logic [15:0] width_cfg;
	logic [63:0] ring [2][RING_DEPTH];
	int          fill [2];
	int          head [2];
	logic [63:0] latest_ts;
	logic [31:0] hist_bins [NUM_BINS];
	logic [31:0] overflow_bins;

	out_item_t   pending_results [$];
	int          error_count;
	int          mismatch_count;
	int          items_sent;
	int          results_seen;
	int          pair_total;
	int          reads_done;
	int          clears_done;
	int          cycle_count;
	logic        no_idle;
	logic        hold_req;
	int          hold_left;
	logic [63:0] now_ts;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic out_item_t predict_histogram(in_item_t it);
		out_item_t   r;
		int          ch;
		int          oc;
		logic [63:0] s;
		logic [63:0] gap;
		logic [32:0] off;
		logic [63:0] bw;
		logic [63:0] bin;
		r = '0;
		if (it.action == ACT_READ) begin
			if (it.bin_select < NUM_BINS)
				r.bin_count = hist_bins[it.bin_select];
			else if (it.bin_select == NUM_BINS)
				r.bin_count = overflow_bins;
		end else if (it.action == ACT_CLEAR) begin
			foreach (hist_bins[i])
				hist_bins[i] = '0;
			overflow_bins = '0;
		end else begin
			ch = (it.action == ACT_PRIMARY) ? 0 : 1;
			oc = 1 - ch;
			if (it.timestamp < latest_ts) begin
				r.status = ST_ORDER;
			end else if (fill[ch] > 0 &&
					ring[ch][(head[ch] + fill[ch] - 1) % RING_DEPTH] == it.timestamp) begin
				r.status = ST_DUP;
			end else begin
				for (int k = 0; k < fill[oc]; k++) begin
					s = ring[oc][(head[oc] + k) % RING_DEPTH];
					gap = it.timestamp - s;
					if (gap <= {32'd0, win_cfg}) begin
						// primary arrives later: dt is negative
						off = (ch == 0) ? {1'b0, win_cfg} - gap[32:0]
						                : {1'b0, win_cfg} + gap[32:0];
						bw = (width_cfg == 0) ? 64'd1 : {48'd0, width_cfg};
						bin = {31'd0, off} / bw;
						if (bin >= NUM_BINS) begin
							if (overflow_bins != COUNT_MAX)
								overflow_bins = overflow_bins + 32'd1;
						end else if (hist_bins[bin] != COUNT_MAX) begin
							hist_bins[bin] = hist_bins[bin] + 32'd1;
						end
						if (r.pairs_found < PAIRS_MAX)
							r.pairs_found = r.pairs_found + 7'd1;
					end
				end
				if (fill[ch] < RING_DEPTH) begin
					ring[ch][(head[ch] + fill[ch]) % RING_DEPTH] = it.timestamp;
					fill[ch]++;
				end else begin
					ring[ch][head[ch]] = it.timestamp;
					head[ch] = (head[ch] + 1) % RING_DEPTH;
					r.status = ST_LOST;
				end
				latest_ts = it.timestamp;
			end
		end
		return r;
	endfunction

	function automatic in_item_t make_item(action_t a, logic [63:0] ts, logic [10:0] sel);
		in_item_t it;
		it.action = a;
		it.timestamp = ts;
		it.bin_select = sel;
		return it;
	endfunction

	// valid stays up after acceptance until the next item or an idle cycle replaces it
	task automatic send_item(in_item_t it);
		logic [95:0] junk;
		while (!no_idle && $urandom_range(0, 99) < 30) begin
			junk = {$urandom, $urandom, $urandom};
			in_valid <= 1'b0;
			in_data <= junk[$bits(in_item_t)-1:0];
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(predict_histogram(it));
		items_sent++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW)
			win_cfg = value;
		else
			width_cfg = value[15:0];
	endtask

	task automatic send_event(int chan, logic [63:0] ts);
		send_item(make_item(chan == 0 ? ACT_PRIMARY : ACT_SECONDARY, ts, 11'($urandom)));
	endtask

	task automatic send_read(logic [10:0] sel);
		send_item(make_item(ACT_READ, {$urandom, $urandom}, sel));
		reads_done++;
	endtask

	task automatic send_clear;
		send_item(make_item(ACT_CLEAR, {$urandom, $urandom}, 11'($urandom)));
		clears_done++;
	endtask

	// mostly ordered streams with random gaps, plus duplicates, stale times, reads, clears
	task automatic random_events(int n, logic [31:0] gap_max);
		int r;
		int chan;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			chan = $urandom_range(0, 1);
			if (r < 78) begin
				now_ts = now_ts + $urandom_range(0, gap_max);
				send_event(chan, now_ts);
			end else if (r < 85) begin
				send_event(chan, now_ts);
			end else if (r < 90) begin
				send_event(chan, latest_ts == 0 ? 64'd0 : {$urandom, $urandom} % latest_ts);
			end else if (r < 98) begin
				send_read(($urandom_range(0, 3) == 0) ? 11'(NUM_BINS) : 11'($urandom));
			end else begin
				send_clear();
			end
		end
	endtask

	task automatic test_directed;
		now_ts = 64'd1000;
		send_read(11'(NUM_BINS));
		send_event(0, 64'd1000);
		send_event(0, 64'd1000);               // duplicate on own channel
		send_event(1, 64'd1000);               // equal time across channels
		send_event(1, 64'd1050);
		send_event(0, 64'd51050);              // exactly at window edge
		send_event(1, 64'd200000);
		send_event(0, 64'd10);                 // stale
		send_read(11'd500);
		send_read(11'd0);
		send_read(11'd1023);
		send_read(11'd1025);                   // beyond overflow slot
		send_read(11'h7FF);
		send_clear();
		send_read(11'd500);
		// fill one ring past depth
		for (int i = 0; i < RING_DEPTH + 3; i++)
			send_event(1, 64'd300000 + i);
		now_ts = 64'd300000 + RING_DEPTH + 3;
		send_event(0, now_ts);                 // pairs with a full ring
		send_read(11'(NUM_BINS));
		drain();
	endtask

	task automatic test_window_extremes;
		write_reg(REG_WINDOW, 32'd0);
		random_events(120, 3);
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		random_events(120, 32'h4000_0000);
		write_reg(REG_WINDOW, 32'd1);
		random_events(80, 2);
		drain();
	endtask

	task automatic test_bin_width_extremes;
		write_reg(REG_WINDOW, 32'd5000);
		write_reg(REG_BIN_WIDTH, 32'd1);
		random_events(120, 200);
		write_reg(REG_BIN_WIDTH, 32'h0000_FFFF);
		write_reg(REG_WINDOW, 32'd20_000_000);
		random_events(120, 4_000_000);
		write_reg(REG_BIN_WIDTH, 32'd0);       // zero acts as one
		write_reg(REG_WINDOW, 32'd600);
		random_events(100, 60);
		drain();
	endtask

	task automatic test_random_mix;
		write_reg(REG_WINDOW, WINDOW_RESET);
		write_reg(REG_BIN_WIDTH, {16'd0, BIN_WIDTH_RESET});
		no_idle = 1'b1;
		random_events(250, 3000);
		no_idle = 1'b0;
		random_events(500, 3000);
		write_reg(REG_WINDOW, 32'h0001_0000);
		write_reg(REG_BIN_WIDTH, 32'd37);
		random_events(250, 2500);
		drain();
	endtask

	task automatic test_backpressure;
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		random_events(40, 2000);
		drain();
	endtask

	task automatic test_top_of_time;
		write_reg(REG_WINDOW, 32'hFFFF_FFFF);
		write_reg(REG_BIN_WIDTH, 32'd4093);
		now_ts = 64'hFFFF_FFFF_0000_0000;
		random_events(80, 32'h0080_0000);
		send_event(1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_event(0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_event(0, 64'h0);
		send_read(11'(NUM_BINS));
		drain();
	endtask

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (mismatch_count < 10)
					$display("unexpected result %p", out_data);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				pair_total += out_data.pairs_found;
				if (out_data.status != want.status || out_data.pairs_found != want.pairs_found
						|| out_data.bin_count != want.bin_count) begin
					error_count++;
					if (mismatch_count < 10)
						$display("mismatch: status %0d/%0d pairs %0d/%0d count %0d/%0d",
							want.status, out_data.status, want.pairs_found,
							out_data.pairs_found, want.bin_count, out_data.bin_count);
					mismatch_count++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			out_stall <= 1'b0;
		end else if (hold_req && hold_left == 0) begin
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 1) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (hold_left == 1)
				hold_left <= 0;
			out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		error_count = 0;
		mismatch_count = 0;
		items_sent = 0;
		results_seen = 0;
		pair_total = 0;
		reads_done = 0;
		clears_done = 0;
		win_cfg = WINDOW_RESET;
		width_cfg = BIN_WIDTH_RESET;
		fill[0] = 0;
		fill[1] = 0;
		head[0] = 0;
		head[1] = 0;
		latest_ts = '0;
		foreach (hist_bins[i])
			hist_bins[i] = '0;
		overflow_bins = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_window_extremes();
		test_bin_width_extremes();
		test_random_mix();
		test_backpressure();
		test_top_of_time();
		drain();

		$display("tb: %0d transactions, %0d results, %0d pairs, %0d reads, %0d clears",
			items_sent, results_seen, pair_total, reads_done, clears_done);
		$display("tb: window and bin width swept through extremes, ring wrap and stale times");
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

[time_coincidence_histogrammer_core.f]
rtl/core/tch_pkg.sv
rtl/core/time_coincidence_histogrammer_core.sv
rtl/core/tch_checker.sv
tb/tb.sv
